>>> src/euler_trs_to_matrix_assert.svh
// assertion macros used by the checker file
`ifndef EULER_TRS_TO_MATRIX_ASSERT_SVH
`define EULER_TRS_TO_MATRIX_ASSERT_SVH

// same-cycle implication
`define ETM_ASSERT_NOW(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
		else $error("etm check failed");

// next-cycle implication
`define ETM_ASSERT_NEXT(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
		else $error("etm check failed");

`endif

>>> src/etm_pkg.sv
package etm_pkg;

	localparam int ANGLE_BITS_DEF     = 16;
	localparam int TRIG_FRAC_BITS_DEF = 15;
	localparam int OUT_FRAC_BITS_DEF  = 16;

	localparam int IN_FRAC_BITS = 16;
	localparam int ANGLE_W      = 16;
	localparam int SCALE_W      = 24;
	localparam int DATA_W       = 32;

	localparam logic [30:0] Q30_ONE     = 31'd1073741824;
	localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

	localparam int HORNER_STEPS = 6;
	localparam int RECIP_SHIFT  = 36;
	localparam int TRIG_LAT     = 2 + 3 * HORNER_STEPS + 2;
	localparam int MAT_LAT      = 5;

	localparam logic [1:0] COL_X    = 2'd0;
	localparam logic [1:0] COL_Y    = 2'd1;
	localparam logic [1:0] COL_Z    = 2'd2;
	localparam logic [1:0] COL_LAST = 2'd3;

	typedef struct packed {
		logic signed [SCALE_W-1:0] scale_x;
		logic signed [SCALE_W-1:0] scale_y;
		logic signed [SCALE_W-1:0] scale_z;
		logic signed [DATA_W-1:0]  shift_x;
		logic signed [DATA_W-1:0]  shift_y;
		logic signed [DATA_W-1:0]  shift_z;
	} side_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
	} col_vec_t;

	// taylor divisor k*(k+1) for horner step i, k running 12 down to 2
	function automatic int horner_div(input int i);
		int k;
		k = 12 - 2 * i;
		return k * (k + 1);
	endfunction

endpackage

>>> src/etm_in_if.sv
interface etm_in_if;
	import etm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [ANGLE_W-1:0]        angle_x;
	logic [ANGLE_W-1:0]        angle_y;
	logic [ANGLE_W-1:0]        angle_z;
	logic signed [SCALE_W-1:0] scale_x;
	logic signed [SCALE_W-1:0] scale_y;
	logic signed [SCALE_W-1:0] scale_z;
	logic signed [DATA_W-1:0]  shift_x;
	logic signed [DATA_W-1:0]  shift_y;
	logic signed [DATA_W-1:0]  shift_z;

	modport source (
		output valid, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z,
			shift_x, shift_y, shift_z,
		input ready
	);
	modport sink (
		input valid, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z,
			shift_x, shift_y, shift_z,
		output ready
	);
endinterface

>>> src/etm_out_if.sv
interface etm_out_if;
	import etm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               col_index;
	logic signed [DATA_W-1:0] out_x;
	logic signed [DATA_W-1:0] out_y;
	logic signed [DATA_W-1:0] out_z;
	logic signed [DATA_W-1:0] out_w;
	logic                     last_col;

	modport source (
		output valid, col_index, out_x, out_y, out_z, out_w, last_col,
		input ready
	);
	modport sink (
		input valid, col_index, out_x, out_y, out_z, out_w, last_col,
		output ready
	);
endinterface

>>> src/etm_trig.sv
module etm_trig #(
	parameter int ANGLE_BITS     = etm_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_FRAC_BITS = etm_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ANGLE_BITS-1:0]         angle,
	output logic signed [TRIG_FRAC_BITS+1:0] value
);
	import etm_pkg::*;

	localparam int QB = ANGLE_BITS - 2;
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << QB;
	localparam logic [31:0] RND  = 32'((64'd1 << (30 - TRIG_FRAC_BITS)) >> 1);
	localparam logic [31:0] VMAX = 32'(64'd1 << TRIG_FRAC_BITS);

	logic [1:0]              quad;
	logic [QB-1:0]           rem_a;
	logic [ANGLE_BITS-2:0]   u;
	logic [ANGLE_BITS+29:0]  u_prod;
	logic [30:0]             x_s1;
	logic                    neg_s1;
	logic [61:0]             sq_prod;
	logic [31:0]             x2_s2;
	logic [30:0]             x_s2;
	logic                    neg_s2;

	logic [31:0] x2_h  [HORNER_STEPS];
	logic [30:0] x_h   [HORNER_STEPS];
	logic [30:0] p_h   [HORNER_STEPS];
	logic        neg_h [HORNER_STEPS];

	logic [61:0]             f_prod;
	logic [30:0]             v_f1;
	logic                    neg_f1;
	logic [31:0]             vr;
	logic [31:0]             vc;
	logic signed [TW-1:0]    mag_s;

	// fold the angle into the first quadrant and scale to radians
	always_comb begin
		quad   = angle[ANGLE_BITS-1 -: 2];
		rem_a  = angle[QB-1:0];
		u      = quad[0] ? QUARTER - (ANGLE_BITS-1)'(rem_a) : (ANGLE_BITS-1)'(rem_a);
		u_prod = (ANGLE_BITS+30)'(u) * (ANGLE_BITS+30)'(PI_HALF_Q30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= u_prod[QB +: 31];
			neg_s1 <= quad[1];
		end
	end

	assign sq_prod = 62'(x_s1) * 62'(x_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s2  <= sq_prod[61:30];
			x_s2   <= x_s1;
			neg_s2 <= neg_s1;
		end
	end

	for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
		localparam int PREV = (i == 0) ? 0 : i - 1;
		localparam int DIV  = horner_div(i);
		localparam logic [33:0] RECIP = 34'((64'd1 << RECIP_SHIFT) / DIV);
		localparam logic [39:0] DIVC  = 40'(DIV);

		logic [31:0] x2_in;
		logic [30:0] x_in;
		logic [30:0] p_in;
		logic        neg_in;
		logic [62:0] prod_a;
		logic [31:0] m_a, x2_a;
		logic [30:0] x_a;
		logic        neg_a;
		logic [65:0] prod_b;
		logic [31:0] m_b, x2_b, q0_b;
		logic [30:0] x_b;
		logic        neg_b;
		logic [39:0] rem_c;
		logic [31:0] q_c;

		assign x2_in  = (i == 0) ? x2_s2  : x2_h[PREV];
		assign x_in   = (i == 0) ? x_s2   : x_h[PREV];
		assign p_in   = (i == 0) ? Q30_ONE : p_h[PREV];
		assign neg_in = (i == 0) ? neg_s2 : neg_h[PREV];

		assign prod_a = 63'(x2_in) * 63'(p_in);

		always_ff @(posedge clk) begin
			if (en) begin
				m_a   <= prod_a[61:30];
				x2_a  <= x2_in;
				x_a   <= x_in;
				neg_a <= neg_in;
			end
		end

		// divide by the constant through its reciprocal, low by at most one
		assign prod_b = 66'(m_a) * 66'(RECIP);

		always_ff @(posedge clk) begin
			if (en) begin
				q0_b  <= prod_b[RECIP_SHIFT +: 32];
				m_b   <= m_a;
				x2_b  <= x2_a;
				x_b   <= x_a;
				neg_b <= neg_a;
			end
		end

		always_comb begin
			rem_c = 40'(m_b) - 40'(q0_b) * DIVC;
			q_c   = (rem_c >= DIVC) ? q0_b + 32'd1 : q0_b;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_h[i]   <= 31'(32'(Q30_ONE) - q_c);
				x2_h[i]  <= x2_b;
				x_h[i]   <= x_b;
				neg_h[i] <= neg_b;
			end
		end
	end

	assign f_prod = 62'(x_h[HORNER_STEPS-1]) * 62'(p_h[HORNER_STEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			v_f1   <= f_prod[60:30];
			neg_f1 <= neg_h[HORNER_STEPS-1];
		end
	end

	// round to the trig format and clamp at one
	always_comb begin
		vr    = (32'(v_f1) + RND) >> (30 - TRIG_FRAC_BITS);
		vc    = (vr > VMAX) ? VMAX : vr;
		mag_s = TW'(vc);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value <= neg_f1 ? -mag_s : mag_s;
		end
	end
endmodule

>>> src/etm_matrix.sv
module etm_matrix #(
	parameter int TRIG_FRAC_BITS = etm_pkg::TRIG_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS  = etm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [TRIG_FRAC_BITS+1:0] sin_x,
	input  logic signed [TRIG_FRAC_BITS+1:0] cos_x,
	input  logic signed [TRIG_FRAC_BITS+1:0] sin_y,
	input  logic signed [TRIG_FRAC_BITS+1:0] cos_y,
	input  logic signed [TRIG_FRAC_BITS+1:0] sin_z,
	input  logic signed [TRIG_FRAC_BITS+1:0] cos_z,
	input  etm_pkg::side_t                   side,
	output etm_pkg::col_vec_t [3:0]          cols
);
	import etm_pkg::*;

	localparam int TW  = TRIG_FRAC_BITS + 2;
	localparam int EW  = TW + 1;
	localparam int PW  = SCALE_W + EW;
	localparam int RW  = ((PW > 41) ? PW : 41) + 1;
	localparam int SH  = IN_FRAC_BITS + TRIG_FRAC_BITS - OUT_FRAC_BITS;
	localparam int LSH = (OUT_FRAC_BITS >= IN_FRAC_BITS) ? OUT_FRAC_BITS - IN_FRAC_BITS : 0;
	localparam int RSH = (OUT_FRAC_BITS < IN_FRAC_BITS) ? IN_FRAC_BITS - OUT_FRAC_BITS : 0;
	localparam logic [2*TW-1:0] THALF = (2*TW)'(1) << (TRIG_FRAC_BITS - 1);
	localparam logic signed [RW-1:0] S32_MAX = RW'(2147483647);
	localparam logic signed [RW-1:0] S32_MIN = ~S32_MAX;

	// trig product, rounded half away from zero
	function automatic logic signed [TW-1:0] tmul(
		input logic signed [TW-1:0] a,
		input logic signed [TW-1:0] b
	);
		logic signed [2*TW-1:0] ae, be, pr, r;
		logic [2*TW-1:0] mag;
		ae  = a;
		be  = b;
		pr  = ae * be;
		mag = pr[2*TW-1] ? -pr : pr;
		mag = (mag + THALF) >> TRIG_FRAC_BITS;
		r   = pr[2*TW-1] ? -$signed(mag) : $signed(mag);
		return r[TW-1:0];
	endfunction

	function automatic logic signed [RW-1:0] rnd(
		input logic signed [RW-1:0] v,
		input logic [5:0] sh
	);
		logic [RW-1:0] mag, half;
		mag  = v[RW-1] ? -v : v;
		half = (RW'(1) << sh) >> 1;
		mag  = (mag + half) >> sh;
		return v[RW-1] ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic [DATA_W-1:0] sat32(input logic signed [RW-1:0] v);
		logic [DATA_W-1:0] r;
		if (v > S32_MAX) begin
			r = 32'h7fff_ffff;
		end else if (v < S32_MIN) begin
			r = 32'h8000_0000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	logic signed [TW-1:0] czcy_s1, cysz_s1, czcx_s1, cysx_s1, szsx_s1, czsx_s1, cycx_s1;
	logic signed [TW-1:0] syx_s1, syc_s1, sz_s1, cz_s1, sy_s1;
	side_t                side_s1;
	logic signed [TW-1:0] czcy_s2, cysz_s2, czcx_s2, cysx_s2, szsx_s2, czsx_s2, cycx_s2, sy_s2;
	logic signed [TW-1:0] czsyx_s2, szsyx_s2, czsyc_s2, szsyc_s2;
	side_t                side_s2;
	logic signed [EW-1:0] e_s3 [9];
	side_t                side_s3;
	logic signed [PW-1:0] prod_s4 [9];
	logic signed [PW-1:0] prod_c [9];
	logic signed [SCALE_W-1:0] scl [3];
	logic signed [DATA_W-1:0]  shf_s4 [3];
	logic signed [DATA_W-1:0]  shf [3];
	col_vec_t [3:0]       cols_s5;
	logic [DATA_W-1:0]    res_c [9];
	logic [DATA_W-1:0]    tr_c [3];

	always_ff @(posedge clk) begin
		if (en) begin
			czcy_s1 <= tmul(cos_z, cos_y);
			cysz_s1 <= tmul(cos_y, sin_z);
			czcx_s1 <= tmul(cos_z, cos_x);
			cysx_s1 <= tmul(cos_y, sin_x);
			szsx_s1 <= tmul(sin_z, sin_x);
			czsx_s1 <= tmul(cos_z, sin_x);
			cycx_s1 <= tmul(cos_y, cos_x);
			syx_s1  <= tmul(sin_y, sin_x);
			syc_s1  <= tmul(sin_y, cos_x);
			sz_s1   <= sin_z;
			cz_s1   <= cos_z;
			sy_s1   <= sin_y;
			side_s1 <= side;
		end
	end

	// second level of the triple products
	always_ff @(posedge clk) begin
		if (en) begin
			czsyx_s2 <= tmul(cz_s1, syx_s1);
			szsyx_s2 <= tmul(sz_s1, syx_s1);
			czsyc_s2 <= tmul(cz_s1, syc_s1);
			szsyc_s2 <= tmul(sz_s1, syc_s1);
			czcy_s2  <= czcy_s1;
			cysz_s2  <= cysz_s1;
			czcx_s2  <= czcx_s1;
			cysx_s2  <= cysx_s1;
			szsx_s2  <= szsx_s1;
			czsx_s2  <= czsx_s1;
			cycx_s2  <= cycx_s1;
			sy_s2    <= sy_s1;
			side_s2  <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s3[0] <= EW'(czcy_s2);
			e_s3[1] <= EW'(cysz_s2);
			e_s3[2] <= -EW'(sy_s2);
			e_s3[3] <= EW'(czsyx_s2) - EW'(cysz_s2);
			e_s3[4] <= EW'(czcx_s2) + EW'(szsyx_s2);
			e_s3[5] <= EW'(cysx_s2);
			e_s3[6] <= EW'(szsx_s2) + EW'(czsyc_s2);
			e_s3[7] <= EW'(szsyc_s2) - EW'(czsx_s2);
			e_s3[8] <= EW'(cycx_s2);
			side_s3 <= side_s2;
		end
	end

	assign scl[0] = side_s3.scale_x;
	assign scl[1] = side_s3.scale_y;
	assign scl[2] = side_s3.scale_z;
	assign shf[0] = side_s3.shift_x;
	assign shf[1] = side_s3.shift_y;
	assign shf[2] = side_s3.shift_z;

	// one scale multiplier per matrix element
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				prod_c[c*3+r] = PW'(scl[c]) * PW'(e_s3[c*3+r]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= prod_c;
			shf_s4  <= shf;
		end
	end

	always_comb begin
		for (int j = 0; j < 9; j++) begin
			res_c[j] = sat32(rnd(RW'(prod_s4[j]), 6'(SH)));
		end
		for (int j = 0; j < 3; j++) begin
			tr_c[j] = sat32(rnd(RW'(shf_s4[j]), 6'(RSH)) <<< LSH);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				cols_s5[c].x <= res_c[c*3];
				cols_s5[c].y <= res_c[c*3+1];
				cols_s5[c].z <= res_c[c*3+2];
			end
			cols_s5[3].x <= tr_c[0];
			cols_s5[3].y <= tr_c[1];
			cols_s5[3].z <= tr_c[2];
		end
	end

	assign cols = cols_s5;
endmodule

>>> src/euler_trs_to_matrix.sv
// transform to model matrix
// xform channel: one transform per item (three binary angles, three Q8.16
// scales, three Q16.16 shifts). column channel: four items per transform,
// col_index 0..3, the translation column last with last_col set and out_w
// equal to one; basis columns carry out_w of zero.
// six trig lanes (sine and cosine of each angle) run a fully pipelined
// taylor evaluation, and the matrix stages form the rotation products and scaling.
// a transform passes the trig lanes and matrix stages into the column register,
// then its columns follow one per cycle while column.ready holds.
// the single column port sets the transform rate; the pipeline itself takes
// a new item every cycle while it is not stalled.
// reset clears the pipeline valid bits and the output stage, nothing else.
// a stalled receiver holds the current column; the pipeline keeps filling
// until a finished transform waits at its end, then xform.ready drops.
module euler_trs_to_matrix #(
	parameter int ANGLE_BITS     = etm_pkg::ANGLE_BITS_DEF,
	parameter int TRIG_FRAC_BITS = etm_pkg::TRIG_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS  = etm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	etm_in_if.sink       xform,
	etm_out_if.source    column
);
	import etm_pkg::*;

	localparam int TW       = TRIG_FRAC_BITS + 2;
	localparam int PIPE_LAT = TRIG_LAT + MAT_LAT;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [DATA_W-1:0] ONE_OUT = DATA_W'(64'd1 << OUT_FRAC_BITS);

	logic [PIPE_LAT-1:0]   vld_q;
	logic                  en, take, load;
	logic                  busy_q;
	logic [1:0]            col_q;
	col_vec_t [3:0]        mat_q;
	col_vec_t [3:0]        mat_cols;
	col_vec_t              cur;
	side_t                 side_in;
	side_t                 side_d [TRIG_LAT];
	logic [ANGLE_BITS-1:0] ang [3];
	logic [ANGLE_BITS-1:0] lane_ang [6];
	logic signed [TW-1:0]  trig_v [6];

	assign ang[0] = ANGLE_BITS'({{ANGLE_BITS{1'b0}}, xform.angle_x});
	assign ang[1] = ANGLE_BITS'({{ANGLE_BITS{1'b0}}, xform.angle_y});
	assign ang[2] = ANGLE_BITS'({{ANGLE_BITS{1'b0}}, xform.angle_z});

	// even lanes sine, odd lanes cosine as sine a quarter turn on
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lane_ang[2*a]   = ang[a];
			lane_ang[2*a+1] = ang[a] + QUARTER;
		end
	end

	for (genvar g = 0; g < 6; g++) begin : g_lane
		etm_trig #(
			.ANGLE_BITS     (ANGLE_BITS),
			.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
		) u_trig (
			.clk   (clk),
			.en    (en),
			.angle (lane_ang[g]),
			.value (trig_v[g])
		);
	end

	assign side_in.scale_x = xform.scale_x;
	assign side_in.scale_y = xform.scale_y;
	assign side_in.scale_z = xform.scale_z;
	assign side_in.shift_x = xform.shift_x;
	assign side_in.shift_y = xform.shift_y;
	assign side_in.shift_z = xform.shift_z;

	// scales and shifts wait alongside the trig lanes
	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_in;
			for (int i = 1; i < TRIG_LAT; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	etm_matrix #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.OUT_FRAC_BITS  (OUT_FRAC_BITS)
	) u_matrix (
		.clk   (clk),
		.en    (en),
		.sin_x (trig_v[0]),
		.cos_x (trig_v[1]),
		.sin_y (trig_v[2]),
		.cos_y (trig_v[3]),
		.sin_z (trig_v[4]),
		.cos_z (trig_v[5]),
		.side  (side_d[TRIG_LAT-1]),
		.cols  (mat_cols)
	);

	assign take = !busy_q || (col_q == COL_LAST && column.ready);
	assign en   = !vld_q[PIPE_LAT-1] || take;
	assign load = vld_q[PIPE_LAT-1] && take;
	assign xform.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], xform.valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= COL_X;
		end else if (load) begin
			busy_q <= 1'b1;
			col_q  <= COL_X;
		end else if (busy_q && column.ready) begin
			if (col_q == COL_LAST) begin
				busy_q <= 1'b0;
			end
			col_q <= col_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mat_q <= mat_cols;
		end
	end

	always_comb begin
		case (col_q)
			COL_X:    cur = mat_q[0];
			COL_Y:    cur = mat_q[1];
			COL_Z:    cur = mat_q[2];
			default:  cur = mat_q[3];
		endcase
	end

	assign column.valid     = busy_q;
	assign column.col_index = col_q;
	assign column.out_x     = cur.x;
	assign column.out_y     = cur.y;
	assign column.out_z     = cur.z;
	assign column.out_w     = (col_q == COL_LAST) ? ONE_OUT : '0;
	assign column.last_col  = (col_q == COL_LAST);
endmodule

>>> src/etm_checker.sv
`include "euler_trs_to_matrix_assert.svh"

module etm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [1:0]  col_index,
	input logic [31:0] out_x,
	input logic [31:0] out_y,
	input logic [31:0] out_z,
	input logic [31:0] out_w,
	input logic        last_col
);
	import etm_pkg::*;

	`ETM_ASSERT_NEXT(a_hold_valid, clk, arst_n, valid && !ready, valid)
	`ETM_ASSERT_NEXT(a_hold_data, clk, arst_n, valid && !ready, $stable(col_index) && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_w))
	// columns of one matrix leave back to back in order
	`ETM_ASSERT_NEXT(a_col_step, clk, arst_n, valid && ready && !last_col, valid && (col_index == $past(col_index) + 2'd1))
	`ETM_ASSERT_NOW(a_last_mark, clk, arst_n, valid, (last_col == (col_index == COL_LAST)) && (last_col || out_w == '0))
endmodule

bind euler_trs_to_matrix etm_checker u_etm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (column.valid),
	.ready     (column.ready),
	.col_index (column.col_index),
	.out_x     (column.out_x),
	.out_y     (column.out_y),
	.out_z     (column.out_z),
	.out_w     (column.out_w),
	.last_col  (column.last_col)
);

>>> dv/euler_trs_to_matrix_tb.sv
`timescale 1ns / 100ps

module euler_trs_to_matrix_tb;
	import etm_pkg::*;

	typedef struct packed {
		logic [15:0] ax, ay, az;
		logic signed [23:0] kx, ky, kz;
		logic signed [31:0] tx, ty, tz;
	} xform_t;

	typedef struct packed {
		logic [1:0] idx;
		logic signed [31:0] x, y, z, w;
		logic last;
	} col_t;

	localparam int WATCHDOG = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	etm_in_if xform ();
	etm_out_if column ();

	euler_trs_to_matrix DUT (
		.clk(clk),
		.arst_n(arst_n),
		.xform(xform.sink),
		.column(column.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	xform_t pending_q[$];
	col_t   column_q[$];
	int     errors = 0;
	int     idle_cnt = 0;
	bit     calm = 1'b0;
	bit     stim_done = 1'b0;
	int     src_gap = 0;
	int     snk_gap = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic longint rnd_shift(input longint v, input int s);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 <<< (s - 1))) >>> s;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint sine_q15(input logic [15:0] a);
		logic [1:0] q;
		longint unsigned r, u, t, x, x2, p, v;
		q = a[15:14];
		r = a[13:0];
		u = q[0] ? 64'd16384 - r : r;
		t = u << 18;
		x = (t * 64'd1686629713) >> 32;
		x2 = (x * x) >> 30;
		p = 64'd1073741824;
		for (int k = 12; k >= 2; k -= 2)
			p = 64'd1073741824 - ((x2 * p) >> 30) / longint'(k * (k + 1));
		v = (x * p) >> 30;
		v = (v + (64'd1 << 14)) >> 15;
		if (v > 64'd32768) v = 64'd32768;
		return q[1] ? -longint'(v) : longint'(v);
	endfunction

	function automatic longint trig_mul(input longint a, input longint b);
		return rnd_shift(a * b, 15);
	endfunction

	function automatic logic [31:0] scale_term(input longint k, input longint e);
		return 32'(clamp32(rnd_shift(k * e, 15)));
	endfunction

	task automatic predict_columns(input xform_t t);
		longint sx, cx, sy, cy, sz, cz, syx, syc, k;
		longint e[3][3];
		col_t c;
		sx = sine_q15(t.ax); cx = sine_q15(t.ax + 16'd16384);
		sy = sine_q15(t.ay); cy = sine_q15(t.ay + 16'd16384);
		sz = sine_q15(t.az); cz = sine_q15(t.az + 16'd16384);
		syx = trig_mul(sy, sx);
		syc = trig_mul(sy, cx);
		e[0][0] = trig_mul(cz, cy);
		e[0][1] = trig_mul(cy, sz);
		e[0][2] = -sy;
		e[1][0] = trig_mul(cz, syx) - trig_mul(cy, sz);
		e[1][1] = trig_mul(cz, cx) + trig_mul(sz, syx);
		e[1][2] = trig_mul(cy, sx);
		e[2][0] = trig_mul(sz, sx) + trig_mul(cz, syc);
		e[2][1] = trig_mul(sz, syc) - trig_mul(cz, sx);
		e[2][2] = trig_mul(cy, cx);
		for (int i = 0; i < 3; i++) begin
			k = i == 0 ? t.kx : (i == 1 ? t.ky : t.kz);
			c.idx = 2'(i);
			c.x = scale_term(k, e[i][0]);
			c.y = scale_term(k, e[i][1]);
			c.z = scale_term(k, e[i][2]);
			c.w = '0;
			c.last = 1'b0;
			column_q.push_back(c);
		end
		c.idx = COL_LAST;
		c.x = t.tx; c.y = t.ty; c.z = t.tz;
		c.w = 32'sd65536;
		c.last = 1'b1;
		column_q.push_back(c);
	endtask

	function automatic xform_t rand_xform();
		xform_t t;
		t.ax = 16'($urandom); t.ay = 16'($urandom); t.az = 16'($urandom);
		t.kx = 24'($urandom); t.ky = 24'($urandom); t.kz = 24'($urandom);
		t.tx = $urandom; t.ty = $urandom; t.tz = $urandom;
		// exact quadrant points and small x scales now and then
		if ($urandom_range(0, 3) == 0) t.ax = 16'($urandom_range(0, 3) << 14);
		if ($urandom_range(0, 3) == 0) t.ay = 16'($urandom_range(0, 3) << 14);
		if ($urandom_range(0, 3) == 0) t.az = 16'($urandom_range(0, 3) << 14);
		if ($urandom_range(0, 2) == 0) t.kx = 24'($signed(17'($urandom)));
		return t;
	endfunction

	initial begin
		xform_t t;
		logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
			16'hFFFF, 16'h3FFF, 16'h0001, 16'h2000};
		for (int i = 0; i < 8; i++) begin
			t.ax = angs[i]; t.ay = angs[(i + 3) % 8]; t.az = angs[(i + 5) % 8];
			t.kx = 24'sh010000; t.ky = -24'sh010000; t.kz = 24'sh7FFFFF;
			t.tx = 32'sh7FFFFFFF; t.ty = 32'sh80000000; t.tz = 32'sd0;
			pending_q.push_back(t);
		end
		// scale extremes
		t = '0;
		t.kx = 24'sh7FFFFF; t.ky = 24'sh800000; t.kz = 24'sh000001;
		t.tx = -32'sd1; t.ty = 32'sd1; t.tz = 32'sh12345678;
		pending_q.push_back(t);
		t.ax = 16'hFFFF; t.ay = 16'hFFFF; t.az = 16'hFFFF;
		t.kx = 24'sh800000; t.ky = 24'sh7FFFFF; t.kz = 24'sh800000;
		pending_q.push_back(t);
		t.ax = 16'h2000; t.ay = 16'h6000; t.az = 16'hA000;
		t.kx = 24'sh800000; t.ky = 24'sh800000; t.kz = 24'sh7FFFFF;
		pending_q.push_back(t);
		t = '1;
		pending_q.push_back(t);
		for (int i = 0; i < 230; i++)
			pending_q.push_back(rand_xform());
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic t_drive();
		xform_t t;
		if (pending_q.size() == 0) begin
			xform.valid <= 1'b0;
			stim_done <= 1'b1;
			return;
		end
		t = pending_q[0];
		xform.valid <= 1'b1;
		xform.angle_x <= t.ax; xform.angle_y <= t.ay; xform.angle_z <= t.az;
		xform.scale_x <= t.kx; xform.scale_y <= t.ky; xform.scale_z <= t.kz;
		xform.shift_x <= t.tx; xform.shift_y <= t.ty; xform.shift_z <= t.tz;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xform.valid <= 1'b0;
			{xform.angle_x, xform.angle_y, xform.angle_z} <= '0;
			{xform.scale_x, xform.scale_y, xform.scale_z} <= '0;
			{xform.shift_x, xform.shift_y, xform.shift_z} <= '0;
		end else begin
			if (xform.valid && xform.ready) begin
				predict_columns(pending_q.pop_front());
			end
			if (pending_q.size() <= 40) calm <= 1'b1;
			if (!(xform.valid && !xform.ready)) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					xform.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					src_gap <= $urandom_range(0, 8);
					xform.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					t_drive();
				end else begin
					xform.valid <= 1'b0;
					stim_done <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		col_t got, exp_c;
		if (!arst_n) begin
			column.ready <= 1'b0;
		end else begin
			if (column.valid && column.ready) begin
				got = '{column.col_index, column.out_x, column.out_y, column.out_z,
					column.out_w, column.last_col};
				if (column_q.size() == 0) begin
					report($sformatf("unexpected column %0d", got.idx));
				end else begin
					exp_c = column_q.pop_front();
					if (got.idx !== exp_c.idx)
						report($sformatf("col_index %0d exp %0d", got.idx, exp_c.idx));
					if (got.x !== exp_c.x)
						report($sformatf("col %0d out_x %h exp %h", exp_c.idx, got.x, exp_c.x));
					if (got.y !== exp_c.y)
						report($sformatf("col %0d out_y %h exp %h", exp_c.idx, got.y, exp_c.y));
					if (got.z !== exp_c.z)
						report($sformatf("col %0d out_z %h exp %h", exp_c.idx, got.z, exp_c.z));
					if (got.w !== exp_c.w)
						report($sformatf("col %0d out_w %h exp %h", exp_c.idx, got.w, exp_c.w));
					if (got.last !== exp_c.last)
						report($sformatf("col %0d last_col %b exp %b", exp_c.idx, got.last,
							exp_c.last));
				end
			end
			if ((column.valid && column.ready) || (xform.valid && xform.ready)) begin
				idle_cnt <= 0;
			end else begin
				idle_cnt <= idle_cnt + 1;
			end
			if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				column.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				snk_gap <= $urandom_range(0, 8);
				column.ready <= 1'b0;
			end else begin
				column.ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (arst_n);
		wait ((stim_done && column_q.size() == 0) || idle_cnt >= WATCHDOG);
		if (idle_cnt >= WATCHDOG) begin
			$display("status: fail");
		end else begin
			repeat (TRIG_LAT + MAT_LAT + 20) @(posedge clk);
			if (errors == 0) begin
				$display("status: pass");
			end else begin
				$display("status: fail");
			end
		end
		$finish;
	end

endmodule
